// File: hw/rtl/spmlf_pkg.sv
// Package for the strict priority multilevel FIFO scheduler.
// Holds sizes, request and status codes and the controller command struct.
// No dependencies; every other file of the block but spmlf_ram uses it.
package spmlf_pkg;

  localparam int LEVELS        = 4;
  localparam int LEVEL_DEPTH   = 16;
  localparam int BLOCKED_DEPTH = 16;
  localparam int PID_BITS      = 8;

  // Fixed field widths of the request and response transactions.
  localparam int ACTION_W = 2;
  localparam int PID_W    = 8;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  // Derived sizes.
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int SLOT_W    = $clog2(LEVEL_DEPTH);
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int RDEPTH    = LEVELS * LEVEL_DEPTH;
  localparam int RADDR_W   = $clog2(RDEPTH);
  localparam int BSLOT_W   = $clog2(BLOCKED_DEPTH);
  localparam int BCNT_W    = $clog2(BLOCKED_DEPTH + 1);
  localparam int BWIDTH    = PRIO_W + PID_BITS;
  localparam int PID_KEEP  = (PID_BITS < PID_W) ? PID_BITS : PID_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_BLOCK   = 2'd2,
    ACT_UNBLOCK = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_PRIO = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // execute the accepted request against the queue state
    logic load;  // move the finished result into the response register
  } spmlf_cmd_t;

endpackage

// File: hw/rtl/spmlf_req_if.sv
// Request channel interface of the scheduler: valid, ready and the payload.
// Depends on spmlf_pkg for field widths.
interface spmlf_req_if;
  logic                          valid;
  logic                          ready;
  logic [spmlf_pkg::ACTION_W-1:0] action;
  logic [spmlf_pkg::PID_W-1:0]    pid;
  logic [spmlf_pkg::PRIO_W-1:0]   prio;

  modport source (output valid, action, pid, prio, input ready);
  modport sink   (input valid, action, pid, prio, output ready);
endinterface

// File: hw/rtl/spmlf_rsp_if.sv
// Response channel interface of the scheduler: valid, ready and the payload.
// Depends on spmlf_pkg for field widths.
interface spmlf_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [spmlf_pkg::STATUS_W-1:0] status;
  logic [spmlf_pkg::PID_W-1:0]    out_pid;
  logic [spmlf_pkg::PRIO_W-1:0]   out_prio;

  modport source (output valid, status, out_pid, out_prio, input ready);
  modport sink   (input valid, status, out_pid, out_prio, output ready);
endinterface

// File: hw/rtl/strict_priority_multilevel_fifo.sv
// Top level of the strict priority multilevel FIFO scheduler.
// Depends on spmlf_pkg, spmlf_req_if, spmlf_rsp_if, spmlf_ctrl and spmlf_dp.
//
//   Channel  Role   Payload                      Meaning
//   req      sink   action, pid, prio            one scheduling request
//   rsp      source status, out_pid, out_prio    one result per request
//
// Each request passes through the idle and finish states: in the accept cycle
// the queue pointers are updated and the queue memory is written or read; in
// the next cycle the registered read data forms the result, which enters the
// response register. The request side is ready again in the cycle after that,
// so a new request is taken only after the last result has been loaded.
// A stalled response holds the result in the finish state and the next request
// waits; a completed result may sit in the response register while the next
// request is accepted. Reset empties every FIFO at once; no clearing pass.
module strict_priority_multilevel_fifo (
  input logic        clk,
  input logic        rst,
  spmlf_req_if.sink   req,
  spmlf_rsp_if.source rsp
);
  import spmlf_pkg::*;

  spmlf_cmd_t cmd;

  // Sequencing and the response valid flag live in the controller.
  spmlf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Queue pointers, the two queue memories and the response payload.
  spmlf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .action   (req.action),
    .pid      (req.pid),
    .prio     (req.prio),
    .status   (rsp.status),
    .out_pid  (rsp.out_pid),
    .out_prio (rsp.out_prio)
  );

  // A request is executed exactly when the request transaction completes.
  a_exec_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.exec == (req.valid && req.ready))
    else $error("request executed without a matching transaction");

  // A request cannot follow directly behind one just accepted.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready && !cmd.exec)
    else $error("second request accepted while one is in flight");

  // The result is loaded only when the response register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!rsp.valid || rsp.ready))
    else $error("result loaded over an untaken response");

  // Every load presents a response in the following cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp.valid)
    else $error("loaded result not presented");

endmodule

// File: hw/rtl/spmlf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spmlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/spmlf_ctrl.sv
// Controller of the scheduler: request/response handshake and sequencing.
// Depends on spmlf_pkg for the command struct.
module spmlf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output spmlf_pkg::spmlf_cmd_t cmd
);
  import spmlf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.exec = (state == S_IDLE) && req_valid;
    cmd.load = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_FINISH;
          end
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          rsp_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/spmlf_dp.sv
// Datapath of the scheduler: FIFO pointers, queue memories and result register.
// Depends on spmlf_pkg and spmlf_ram.
module spmlf_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  spmlf_pkg::spmlf_cmd_t          cmd,
  input  logic [spmlf_pkg::ACTION_W-1:0] action,
  input  logic [spmlf_pkg::PID_W-1:0]    pid,
  input  logic [spmlf_pkg::PRIO_W-1:0]   prio,
  output logic [spmlf_pkg::STATUS_W-1:0] status,
  output logic [spmlf_pkg::PID_W-1:0]    out_pid,
  output logic [spmlf_pkg::PRIO_W-1:0]   out_prio
);
  import spmlf_pkg::*;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_READY,
    SRC_BLOCKED
  } src_t;

  // Per-level ready FIFO pointers and the blocked FIFO pointers.
  logic [SLOT_W-1:0]  head  [LEVELS];
  logic [CNT_W-1:0]   count [LEVELS];
  logic [BSLOT_W-1:0] bhead;
  logic [BCNT_W-1:0]  bcount;

  // Result held between execution and the response register.
  status_t       res_status;
  src_t          res_src;
  logic [LVL_W-1:0] res_lvl;

  // Memory ports.
  logic               r_we, r_re, b_we, b_re;
  logic [RADDR_W-1:0] r_waddr, r_raddr;
  logic [PID_BITS-1:0] r_wdata, r_rdata;
  logic [BSLOT_W-1:0] b_waddr, b_raddr;
  logic [BWIDTH-1:0]  b_wdata, b_rdata;

  // Decode of the current request.
  action_t             act;
  logic [LVL_W-1:0]    enq_lvl;
  logic                bad_prio;
  logic [LVL_W-1:0]    pop_lvl;
  logic                any_ready;
  logic [CNT_W:0]      enq_sum;
  logic [SLOT_W-1:0]   enq_slot;
  logic [BCNT_W:0]     blk_sum;
  logic [BSLOT_W-1:0]  blk_slot;
  logic [PID_BITS-1:0] pid_kept;
  status_t             status_next;
  src_t                src_next;
  logic                push_ready, pop_ready, push_blocked, pop_blocked;

  assign act      = action_t'(action);
  assign enq_lvl  = prio[LVL_W-1:0];
  assign bad_prio = ({1'b0, prio} >= (PRIO_W+1)'(LEVELS));
  assign pid_kept = PID_BITS'(pid[PID_KEEP-1:0]);

  // The lowest-numbered non-empty level wins.
  always_comb begin
    pop_lvl   = '0;
    any_ready = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        pop_lvl   = LVL_W'(i);
        any_ready = 1'b1;
      end
    end
  end

  // Tail slots: head plus fill, folded once back into the ring.
  always_comb begin
    enq_sum  = (CNT_W+1)'(head[enq_lvl]) + (CNT_W+1)'(count[enq_lvl]);
    enq_slot = (enq_sum >= (CNT_W+1)'(LEVEL_DEPTH))
             ? SLOT_W'(enq_sum - (CNT_W+1)'(LEVEL_DEPTH)) : SLOT_W'(enq_sum);
    blk_sum  = (BCNT_W+1)'(bhead) + (BCNT_W+1)'(bcount);
    blk_slot = (blk_sum >= (BCNT_W+1)'(BLOCKED_DEPTH))
             ? BSLOT_W'(blk_sum - (BCNT_W+1)'(BLOCKED_DEPTH)) : BSLOT_W'(blk_sum);
  end

  always_comb begin
    status_next  = ST_DONE;
    src_next     = SRC_NONE;
    push_ready   = 1'b0;
    pop_ready    = 1'b0;
    push_blocked = 1'b0;
    pop_blocked  = 1'b0;
    case (act)
      ACT_ENQUEUE: begin
        if (bad_prio) begin
          status_next = ST_BAD_PRIO;
        end else if (count[enq_lvl] == CNT_W'(LEVEL_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          push_ready = 1'b1;
        end
      end
      ACT_DEQUEUE: begin
        if (!any_ready) begin
          status_next = ST_EMPTY;
        end else begin
          pop_ready = 1'b1;
          src_next  = SRC_READY;
        end
      end
      ACT_BLOCK: begin
        if (bcount == BCNT_W'(BLOCKED_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          push_blocked = 1'b1;
        end
      end
      ACT_UNBLOCK: begin
        if (bcount == '0) begin
          status_next = ST_EMPTY;
        end else begin
          pop_blocked = 1'b1;
          src_next    = SRC_BLOCKED;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  assign r_we    = cmd.exec && push_ready;
  assign r_waddr = RADDR_W'(enq_lvl) * RADDR_W'(LEVEL_DEPTH) + RADDR_W'(enq_slot);
  assign r_wdata = pid_kept;
  assign r_re    = cmd.exec && pop_ready;
  assign r_raddr = RADDR_W'(pop_lvl) * RADDR_W'(LEVEL_DEPTH) + RADDR_W'(head[pop_lvl]);
  assign b_we    = cmd.exec && push_blocked;
  assign b_waddr = blk_slot;
  assign b_wdata = {prio, pid_kept};
  assign b_re    = cmd.exec && pop_blocked;
  assign b_raddr = bhead;

  spmlf_ram #(.WIDTH(PID_BITS), .DEPTH(RDEPTH)) u_ready_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (r_re),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  spmlf_ram #(.WIDTH(BWIDTH), .DEPTH(BLOCKED_DEPTH)) u_blocked_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      bhead  <= '0;
      bcount <= '0;
    end else if (cmd.exec) begin
      if (push_ready) begin
        count[enq_lvl] <= count[enq_lvl] + CNT_W'(1);
      end
      if (pop_ready) begin
        count[pop_lvl] <= count[pop_lvl] - CNT_W'(1);
        head[pop_lvl]  <= (head[pop_lvl] == SLOT_W'(LEVEL_DEPTH - 1))
                        ? '0 : head[pop_lvl] + SLOT_W'(1);
      end
      if (push_blocked) begin
        bcount <= bcount + BCNT_W'(1);
      end
      if (pop_blocked) begin
        bcount <= bcount - BCNT_W'(1);
        bhead  <= (bhead == BSLOT_W'(BLOCKED_DEPTH - 1)) ? '0 : bhead + BSLOT_W'(1);
      end
    end
  end

  // Result bookkeeping and the response payload register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      res_src    <= src_next;
      res_lvl    <= pop_lvl;
    end
    if (cmd.load) begin
      status <= res_status;
      case (res_src)
        SRC_READY: begin
          out_pid  <= PID_W'(r_rdata[PID_KEEP-1:0]);
          out_prio <= PRIO_W'(res_lvl);
        end
        SRC_BLOCKED: begin
          out_pid  <= PID_W'(b_rdata[PID_KEEP-1:0]);
          out_prio <= b_rdata[PID_BITS +: PRIO_W];
        end
        default: begin
          out_pid  <= '0;
          out_prio <= '0;
        end
      endcase
    end
  end

endmodule
